### rtl/core/plic_pkg.sv
// Package for the platform interrupt controller: sizes, register map,
// command codes and the priority memory geometry. No dependencies.
package plic_pkg;

    // Block size.
    localparam int NUM_SOURCES   = 64;
    localparam int PRIORITY_BITS = 3;

    // Field widths of the request and response words.
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 22;
    localparam int DATA_W   = 32;
    localparam int LINE_W   = 64;
    localparam int LINE_IDX_W = 6;

    // Source id width and the number of 32-bit words of pending and enable bits.
    localparam int SRC_W    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int NWORDS   = (NUM_SOURCES + 31) / 32;
    localparam int WPAD     = NWORDS * 32;
    localparam int WORD_IDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    // Priority memory: each row holds the priorities of LANES sources.
    localparam int LANES    = 4;
    localparam int LANE_W   = 2;
    localparam int ROWS     = (NUM_SOURCES + LANES - 1) / LANES;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_BITS = LANES * PRIORITY_BITS;
    localparam int SRC_PAD  = ROWS * LANES;
    localparam int IDX_W    = ROW_W + LANE_W;
    localparam int CNT_W    = $clog2(ROWS + 1);

    // Sources that exist: every id below NUM_SOURCES except id zero.
    localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

    // Commands.
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;

    // Register map, byte offsets.
    localparam logic [ADDR_W-1:0] PRIO_BASE   = 22'h000000;
    localparam logic [ADDR_W-1:0] PEND_BASE   = 22'h001000;
    localparam logic [ADDR_W-1:0] PEND_END    = 22'h001080;
    localparam logic [ADDR_W-1:0] ENAB_BASE   = 22'h002000;
    localparam logic [ADDR_W-1:0] ENAB_END    = 22'h002080;
    localparam logic [ADDR_W-1:0] THRESH_ADDR = 22'h200000;
    localparam logic [ADDR_W-1:0] CLAIM_ADDR  = 22'h200004;

endpackage

### rtl/core/plic_if.sv
// Valid/ready channel interfaces of the platform interrupt controller.
// Depends on plic_pkg for the field widths.
interface plic_req_if;
    logic                            valid;
    logic                            ready;
    logic [plic_pkg::CMD_W-1:0]      command;
    logic [plic_pkg::ADDR_W-1:0]     reg_address;
    logic [plic_pkg::DATA_W-1:0]     write_data;
    logic [plic_pkg::LINE_W-1:0]     source_lines;

    modport source (output valid, command, reg_address, write_data, source_lines,
                    input ready);
    modport sink   (input valid, command, reg_address, write_data, source_lines,
                    output ready);
endinterface

interface plic_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [plic_pkg::DATA_W-1:0]     read_data;
    logic                            machine_irq;

    modport source (output valid, read_data, machine_irq, input ready);
    modport sink   (input valid, read_data, machine_irq, output ready);
endinterface

### rtl/core/platform_interrupt_controller.sv
// Platform interrupt controller for one machine context: gateway, registers,
// priority memory and the iterative claim search. Depends on plic_pkg, plic_if.
//
// Usage. Requests arrive as words on i_req: a sample of the source lines, a
// bus read or a bus write of the register map (priorities, pending words,
// enable words, threshold, claim/complete). Every request gives exactly one
// response word on o_rsp carrying the read data (zero unless a read) and the
// machine interrupt line as it stands after the request.
//
// Timing. A request is taken at a rising edge and executed in the next cycle.
// Then the priority memory is swept one row of four sources per cycle to find
// the best claimable source, and the response register is then loaded once it
// is free. The block is ready again in the same cycle as the response word
// becomes valid, so a new request is taken only after the last one's response
// is loaded. Most of the time per request goes to the sweep over the single
// memory read port.
// Reset clears all priorities, pending, enable and in-service bits and the
// threshold (priorities through per-entry valid bits). If the receiver stalls,
// the response waits in its register; the next request is still taken, and its
// own response waits until the register is free.
module platform_interrupt_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    plic_req_if.sink        i_req,
    plic_rsp_if.source      o_rsp
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int NS = plic_pkg::NUM_SOURCES;
    localparam int PB = plic_pkg::PRIORITY_BITS;

    // Control and architectural state.
    logic [1:0]                       r_state, n_state;
    logic [NS-1:0]                    r_pend, n_pend;
    logic [NS-1:0]                    r_en, n_en;
    logic [NS-1:0]                    r_isv, n_isv;
    logic [PB-1:0]                    r_thr, n_thr;
    logic [plic_pkg::SRC_PAD-1:0]     r_pri_vld, n_pri_vld;
    logic [plic_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                             r_rd_vld, n_rd_vld;
    logic                             r_out_vld, n_out_vld;

    // Latched request and search results.
    logic [plic_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [plic_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic [plic_pkg::DATA_W-1:0]      r_wdata, n_wdata;
    logic [plic_pkg::LINE_W-1:0]      r_lines, n_lines;
    logic [plic_pkg::ROW_W-1:0]       r_rd_row, n_rd_row;
    logic [plic_pkg::SRC_W-1:0]       r_best, n_best;
    logic [PB-1:0]                    r_best_p, n_best_p;
    logic [1:0]                       r_cnd_cnt, n_cnd_cnt;
    logic [plic_pkg::DATA_W-1:0]      r_rdata, n_rdata;
    logic [plic_pkg::DATA_W-1:0]      r_out_rdata, n_out_rdata;
    logic                             r_out_irq, n_out_irq;

    // Priority memory, one row per four sources, one read and one write port.
    logic [plic_pkg::ROW_BITS-1:0]    mem_pri [plic_pkg::ROWS];
    logic [plic_pkg::ROW_BITS-1:0]    r_mem_q;
    logic                             mem_we;
    logic [plic_pkg::ROW_W-1:0]       mem_wrow;
    logic [plic_pkg::LANE_W-1:0]      mem_wlane;
    logic [plic_pkg::ROW_W-1:0]       mem_raddr;

    // Address decode of the latched request.
    logic                             is_pri, is_pend, is_enab, is_thr, is_claim;
    logic [9:0]                       pri_idx;
    logic                             pri_ok;
    logic [4:0]                       word_sel;
    logic                             word_ok;
    logic [plic_pkg::WORD_IDX_W-1:0]  word_idx;
    logic                             out_load;

    always_comb begin
        pri_idx  = r_addr[11:2];
        pri_ok   = (32'(pri_idx) < 32'(NS));
        word_sel = r_addr[6:2];
        word_ok  = (32'(word_sel) < 32'(plic_pkg::NWORDS));
        word_idx = plic_pkg::WORD_IDX_W'(word_sel);
        is_pri   = (r_addr < plic_pkg::PEND_BASE);
        is_pend  = (r_addr >= plic_pkg::PEND_BASE) && (r_addr < plic_pkg::PEND_END);
        is_enab  = (r_addr >= plic_pkg::ENAB_BASE) && (r_addr < plic_pkg::ENAB_END);
        is_thr   = (r_addr == plic_pkg::THRESH_ADDR);
        is_claim = (r_addr == plic_pkg::CLAIM_ADDR);
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.read_data   = r_out_rdata;
    assign o_rsp.machine_irq = r_out_irq;

    assign out_load = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    always_comb begin
        logic [NS-1:0]                 line_vec;
        logic [plic_pkg::WPAD-1:0]     word_vec;
        logic [plic_pkg::SRC_PAD-1:0]  pend_s;
        logic [plic_pkg::SRC_PAD-1:0]  en_s;
        logic [plic_pkg::IDX_W-1:0]    idx;
        logic [PB-1:0]                 p;
        logic                          cand;
        logic [plic_pkg::SRC_W-1:0]    cid;

        n_state     = r_state;
        n_pend      = r_pend;
        n_en        = r_en;
        n_isv       = r_isv;
        n_thr       = r_thr;
        n_pri_vld   = r_pri_vld;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_rd_row    = r_rd_row;
        n_out_vld   = r_out_vld;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_wdata     = r_wdata;
        n_lines     = r_lines;
        n_best      = r_best;
        n_best_p    = r_best_p;
        n_cnd_cnt   = r_cnd_cnt;
        n_rdata     = r_rdata;
        n_out_rdata = r_out_rdata;
        n_out_irq   = r_out_irq;
        mem_we      = 1'b0;
        mem_wrow    = plic_pkg::ROW_W'(pri_idx >> plic_pkg::LANE_W);
        mem_wlane   = pri_idx[plic_pkg::LANE_W-1:0];
        mem_raddr   = plic_pkg::ROW_W'(pri_idx >> plic_pkg::LANE_W);
        pend_s      = plic_pkg::SRC_PAD'(r_pend);
        en_s        = plic_pkg::SRC_PAD'(r_en);
        cid         = plic_pkg::SRC_W'(r_wdata);
        word_vec    = '0;
        idx         = '0;
        p           = '0;
        cand        = 1'b0;

        // Source lines beyond the 64-bit field are never high.
        for (int i = 0; i < NS; i++) begin
            if (i < plic_pkg::LINE_W) begin
                line_vec[i] = r_lines[i[plic_pkg::LINE_IDX_W-1:0]];
            end else begin
                line_vec[i] = 1'b0;
            end
        end

        if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd   = i_req.command;
                    n_addr  = {i_req.reg_address[plic_pkg::ADDR_W-1:2], 2'b00};
                    n_wdata = i_req.write_data;
                    n_lines = i_req.source_lines;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // Apply everything but the claim; the priority row read for a
                // priority register read is issued here and lands next cycle.
                n_rdata   = '0;
                n_best    = '0;
                n_best_p  = '0;
                n_cnd_cnt = 2'd0;
                n_cnt     = '0;
                n_state   = S_SCAN;
                if (r_cmd == plic_pkg::CMD_SAMPLE) begin
                    // A line sets pending unless the source is already in service.
                    n_pend = r_pend | (line_vec & ~r_isv & plic_pkg::SRC_MASK);
                end else if (r_cmd == plic_pkg::CMD_READ) begin
                    if (is_pend && word_ok) begin
                        word_vec = plic_pkg::WPAD'(r_pend);
                        n_rdata  = word_vec[32*word_idx +: 32];
                    end else if (is_enab && word_ok) begin
                        word_vec = plic_pkg::WPAD'(r_en);
                        n_rdata  = word_vec[32*word_idx +: 32];
                    end else if (is_thr) begin
                        n_rdata = plic_pkg::DATA_W'(r_thr);
                    end
                end else if (r_cmd == plic_pkg::CMD_WRITE) begin
                    if (is_pri) begin
                        if (pri_ok && (pri_idx != '0)) begin
                            mem_we = 1'b1;
                            n_pri_vld[plic_pkg::IDX_W'(pri_idx)] = 1'b1;
                        end
                    end else if (is_enab) begin
                        if (word_ok) begin
                            word_vec = plic_pkg::WPAD'(r_en);
                            word_vec[32*word_idx +: 32] = r_wdata;
                            n_en = word_vec[NS-1:0] & plic_pkg::SRC_MASK;
                        end
                    end else if (is_thr) begin
                        n_thr = r_wdata[PB-1:0];
                    end else if (is_claim) begin
                        if ((r_wdata != '0) && (r_wdata < 32'(NS)) && r_en[cid]) begin
                            n_isv[cid] = 1'b0;
                        end
                    end
                end
            end

            S_SCAN: begin
                // The first cycle still sees the row read issued by the execute step.
                if ((r_cnt == '0) && (r_cmd == plic_pkg::CMD_READ) && is_pri && pri_ok
                    && r_pri_vld[plic_pkg::IDX_W'(pri_idx)]) begin
                    n_rdata = plic_pkg::DATA_W'(r_mem_q[32'(mem_wlane)*PB +: PB]);
                end
                if (32'(r_cnt) < 32'(plic_pkg::ROWS)) begin
                    mem_raddr = plic_pkg::ROW_W'(r_cnt);
                    n_rd_vld  = 1'b1;
                    n_rd_row  = plic_pkg::ROW_W'(r_cnt);
                    n_cnt     = r_cnt + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
                // Lanes in ascending id; a strict compare keeps the lowest id on a tie.
                if (r_rd_vld) begin
                    for (int l = 0; l < plic_pkg::LANES; l++) begin
                        idx  = {r_rd_row, l[plic_pkg::LANE_W-1:0]};
                        p    = r_pri_vld[idx] ? r_mem_q[l*PB +: PB] : '0;
                        cand = pend_s[idx] && en_s[idx] && (p > r_thr);
                        if (cand) begin
                            if (n_cnd_cnt != 2'd2) begin
                                n_cnd_cnt = n_cnd_cnt + 2'd1;
                            end
                            if (p > n_best_p) begin
                                n_best   = plic_pkg::SRC_W'(idx);
                                n_best_p = p;
                            end
                        end
                    end
                end
            end

            S_DONE: begin
                if (out_load) begin
                    n_out_vld   = 1'b1;
                    n_out_rdata = r_rdata;
                    n_out_irq   = (r_cnd_cnt != 2'd0);
                    if ((r_cmd == plic_pkg::CMD_READ) && is_claim && (r_best != '0)) begin
                        // The winner leaves the candidate set, so another must remain.
                        n_pend[r_best] = 1'b0;
                        n_isv[r_best]  = 1'b1;
                        n_out_rdata    = plic_pkg::DATA_W'(r_best);
                        n_out_irq      = (r_cnd_cnt == 2'd2);
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= '0;
            r_en      <= '0;
            r_isv     <= '0;
            r_thr     <= '0;
            r_pri_vld <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_en      <= n_en;
            r_isv     <= n_isv;
            r_thr     <= n_thr;
            r_pri_vld <= n_pri_vld;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_addr      <= n_addr;
        r_wdata     <= n_wdata;
        r_lines     <= n_lines;
        r_rd_row    <= n_rd_row;
        r_best      <= n_best;
        r_best_p    <= n_best_p;
        r_cnd_cnt   <= n_cnd_cnt;
        r_rdata     <= n_rdata;
        r_out_rdata <= n_out_rdata;
        r_out_irq   <= n_out_irq;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_pri[mem_wrow][32'(mem_wlane)*PB +: PB] <= r_wdata[PB-1:0];
        end
        r_mem_q <= mem_pri[mem_raddr];
    end

    // A source is never pending and in service at the same time.
    a_pend_isv_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & r_isv) == '0)
        else $error("source both pending and in service");

    // Source zero never holds pending, enable or in-service state.
    a_src0_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pend[0] && !r_en[0] && !r_isv[0])
        else $error("source zero holds state");

    // Only a bus read returns nonzero data.
    a_rdata_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_cmd != plic_pkg::CMD_READ)) |=> (o_rsp.read_data == '0))
        else $error("nonzero read data for a non-read request");

    // A claim hands out a source that is then in service and no longer pending.
    a_claim_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_cmd == plic_pkg::CMD_READ) && is_claim && (r_best != '0))
        |=> (r_isv[$past(r_best)] && !r_pend[$past(r_best)]))
        else $error("claimed source not marked in service");

endmodule

### tb/tb.sv
// Self-checking testbench for platform_interrupt_controller: drives sample, read and write
// words, predicts every response from a shadow copy of the controller and compares them.
// Depends on plic_pkg and the plic_req_if / plic_rsp_if channel interfaces.
`timescale 1ns / 100ps

module tb;
    import plic_pkg::*;

    // The command field has one code that the controller does not define.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1024;
    localparam int QUIET_WORDS  = 150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    // Which ids exist as real sources, padded to whole 32-bit register words.
    localparam logic [WPAD-1:0] SRC_EXIST = WPAD'(SRC_MASK);

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              machine_irq;
    } plic_result_t;

    // One request word, plus a hand-written response for the directed rows where the
    // answer is obvious; everything else takes its response from the shadow model.
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [LINE_W-1:0] lines;
        bit                typed;
        plic_result_t      want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    plic_req_if req_ch ();
    plic_rsp_if rsp_ch ();

    platform_interrupt_controller u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // 20 ns clock period.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Shadow copy of the controller state. It is updated in acceptance order, so it always
    // reflects the state the controller will have once it has executed the same words.
    logic [PRIORITY_BITS-1:0] shadow_prio [NUM_SOURCES];
    logic [WPAD-1:0]          shadow_pend;
    logic [WPAD-1:0]          shadow_enab;
    logic [WPAD-1:0]          shadow_insvc;
    logic [PRIORITY_BITS-1:0] shadow_thresh;

    // Responses still owed by the controller, oldest first.
    plic_result_t awaited_results [$];

    int  fail_count;
    int  cycle_count;
    int  sample_count, read_count, write_count, other_count;
    int  grants;
    int  irq_seen;
    bit  quiet_tail;
    bit  src_idle_on;
    bit  snk_idle_on;

    // Claim arbitration: the enabled, pending source whose priority is strictly above the
    // threshold. A strictly greater test while scanning upward keeps the lowest id on a tie.
    function automatic int top_claimable();
        int best;
        int best_p;
        best   = 0;
        best_p = 0;
        for (int s = 1; s < NUM_SOURCES; s++) begin
            if (shadow_pend[s] && shadow_enab[s] && shadow_prio[s] > shadow_thresh &&
                int'(shadow_prio[s]) > best_p) begin
                best   = s;
                best_p = shadow_prio[s];
            end
        end
        return best;
    endfunction

    // Executes one accepted word on the shadow state and returns the response it owes.
    function automatic plic_result_t plic_execute(input logic [CMD_W-1:0]  cmd,
                                                  input logic [ADDR_W-1:0] raw_addr,
                                                  input logic [DATA_W-1:0] wdata,
                                                  input logic [LINE_W-1:0] lines);
        plic_result_t      r;
        logic [ADDR_W-1:0] a;
        int                idx;
        int                id;
        r.read_data = '0;
        // The two low address bits never select anything.
        a = {raw_addr[ADDR_W-1:2], 2'b00};
        case (cmd)
            CMD_SAMPLE: begin
                // The gateway only forwards a high line when the source is idle; a line
                // that drops later leaves its pending bit alone.
                shadow_pend = shadow_pend | (WPAD'(lines) & ~shadow_insvc & SRC_EXIST);
            end
            CMD_READ: begin
                if (a < PEND_BASE) begin
                    idx = a >> 2;
                    if (idx < NUM_SOURCES)
                        r.read_data = DATA_W'(shadow_prio[idx]);
                end else if (a < PEND_END) begin
                    idx = (a - PEND_BASE) >> 2;
                    if (idx < NWORDS)
                        r.read_data = shadow_pend[32*idx +: 32];
                end else if (a >= ENAB_BASE && a < ENAB_END) begin
                    idx = (a - ENAB_BASE) >> 2;
                    if (idx < NWORDS)
                        r.read_data = shadow_enab[32*idx +: 32];
                end else if (a == THRESH_ADDR) begin
                    r.read_data = DATA_W'(shadow_thresh);
                end else if (a == CLAIM_ADDR) begin
                    // A claim moves the winner from pending to in service.
                    id = top_claimable();
                    if (id != 0) begin
                        shadow_pend[id]  = 1'b0;
                        shadow_insvc[id] = 1'b1;
                        grants++;
                    end
                    r.read_data = DATA_W'(id);
                end
            end
            CMD_WRITE: begin
                if (a < PEND_BASE) begin
                    idx = a >> 2;
                    if (idx != 0 && idx < NUM_SOURCES)
                        shadow_prio[idx] = wdata[PRIORITY_BITS-1:0];
                end else if (a >= ENAB_BASE && a < ENAB_END) begin
                    idx = (a - ENAB_BASE) >> 2;
                    if (idx < NWORDS)
                        shadow_enab[32*idx +: 32] = wdata & SRC_EXIST[32*idx +: 32];
                end else if (a == THRESH_ADDR) begin
                    shadow_thresh = wdata[PRIORITY_BITS-1:0];
                end else if (a == CLAIM_ADDR) begin
                    // Completion only counts for a real, currently enabled source.
                    if (wdata != 0 && wdata < NUM_SOURCES && shadow_enab[wdata[SRC_W-1:0]])
                        shadow_insvc[wdata[SRC_W-1:0]] = 1'b0;
                end
                // Writes to the pending words and to unmapped space are dropped.
            end
            default: begin
            end
        endcase
        r.machine_irq = (top_claimable() != 0);
        return r;
    endfunction

    function automatic stim_row_t dir_row(input logic [CMD_W-1:0]  cmd,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data,
                                          input logic [LINE_W-1:0] lines,
                                          input bit                typed,
                                          input logic [DATA_W-1:0] rd,
                                          input logic              irq);
        stim_row_t w;
        w.cmd   = cmd;
        w.addr  = addr;
        w.data  = data;
        w.lines = lines;
        w.typed = typed;
        w.want.read_data   = rd;
        w.want.machine_irq = irq;
        return w;
    endfunction

    // Presents one request word, holds it until the controller takes it, and records the
    // response it owes. A random gap of idle cycles may come first. Only one nonblocking
    // assignment to valid happens per time step: either the gap lowers it, or the new word
    // keeps it high.
    task automatic drive_word(input stim_row_t w);
        plic_result_t predicted;
        if (!quiet_tail && src_idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= w.cmd;
        req_ch.reg_address  <= w.addr;
        req_ch.write_data   <= w.data;
        req_ch.source_lines <= w.lines;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        // Accepted at this edge: the shadow state moves on in the same order.
        predicted = plic_execute(w.cmd, w.addr, w.data, w.lines);
        awaited_results.push_back(w.typed ? w.want : predicted);
        case (w.cmd)
            CMD_SAMPLE: sample_count++;
            CMD_READ:   read_count++;
            CMD_WRITE:  write_count++;
            default:    other_count++;
        endcase
    endtask

    // Response side: random stalls in bursts, switched off for the last stretch of the run.
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!quiet_tail && snk_idle_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Response checker. Values are sampled at the edge, before this edge's updates land.
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_ch.machine_irq === 1'b1)
                irq_seen++;
            if (awaited_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("[%0t] unexpected response word: read_data=%h machine_irq=%b",
                             $realtime, rsp_ch.read_data, rsp_ch.machine_irq);
            end else begin
                plic_result_t exp_r;
                exp_r = awaited_results.pop_front();
                if (rsp_ch.read_data !== exp_r.read_data ||
                    rsp_ch.machine_irq !== exp_r.machine_irq) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("[%0t] response mismatch: read_data exp %h got %h, %s%b got %b",
                                 $realtime, exp_r.read_data, rsp_ch.read_data,
                                 "machine_irq exp ", exp_r.machine_irq, rsp_ch.machine_irq);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        stim_row_t directed_rows [$];
        stim_row_t w;
        int        sel;
        int        src;
        int        wi;
        int        busy_ids [$];

        fail_count   = 0;
        cycle_count  = 0;
        sample_count = 0;
        read_count   = 0;
        write_count  = 0;
        other_count  = 0;
        grants       = 0;
        irq_seen     = 0;
        quiet_tail   = 1'b0;
        src_idle_on  = 1'b1;
        snk_idle_on  = 1'b1;
        foreach (shadow_prio[s]) shadow_prio[s] = '0;
        shadow_pend   = '0;
        shadow_enab   = '0;
        shadow_insvc  = '0;
        shadow_thresh = '0;

        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.command       <= CMD_SAMPLE;
        req_ch.reg_address   <= '0;
        req_ch.write_data    <= '0;
        req_ch.source_lines  <= '0;

        // Directed rows. Typed responses are the ones that follow directly from the
        // register map: reset values, masked widths, ignored writes and plain claims.
        // Reset state, and a claim with nothing to claim.
        directed_rows.push_back(dir_row(CMD_READ,  PRIO_BASE, '0, '0, 1, 32'd0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  PEND_BASE, '0, '0, 1, 32'd0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  CLAIM_ADDR, '0, '0, 1, 32'd0, 1'b0));
        // Source zero has no priority register.
        directed_rows.push_back(dir_row(CMD_WRITE, PRIO_BASE, '1, '0, 1, 32'd0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  PRIO_BASE, '0, '0, 1, 32'd0, 1'b0));
        // The last source takes the top priority; only PRIORITY_BITS bits are kept.
        directed_rows.push_back(dir_row(CMD_WRITE, PRIO_BASE + 22'h0FC, '1, '0, 1, 32'd0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  PRIO_BASE + 22'h0FC, '0, '0, 1, 32'd7, 1'b0));
        // One past the last source: reads zero, write dropped.
        directed_rows.push_back(dir_row(CMD_WRITE, PRIO_BASE + 22'h100, '1, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  PRIO_BASE + 22'h100, '0, '0, 1, 32'd0, 1'b0));
        // Enable everything; bit zero of the first word cannot be set.
        directed_rows.push_back(dir_row(CMD_WRITE, ENAB_BASE, '1, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  ENAB_BASE, '0, '0, 1, 32'hFFFF_FFFE, 1'b0));
        directed_rows.push_back(dir_row(CMD_WRITE, ENAB_BASE + 22'h4, '1, '0, 0, '0, 1'b0));
        // All lines high: every real source goes pending and the last one is claimable.
        directed_rows.push_back(dir_row(CMD_SAMPLE, '0, '0, '1, 1, 32'd0, 1'b1));
        // The pending words are read-only.
        directed_rows.push_back(dir_row(CMD_WRITE, PEND_BASE, '0, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  PEND_BASE + 22'h4, '0, '0, 1, '1, 1'b1));
        // Top of the address space is unmapped.
        directed_rows.push_back(dir_row(CMD_READ,  22'h3FFFFF, '0, '0, 1, 32'd0, 1'b1));
        // Claim through an unaligned address; no one else is above the threshold.
        directed_rows.push_back(dir_row(CMD_READ,  CLAIM_ADDR | 22'h3, '0, '0, 1, 32'd63, 1'b0));
        // A source in service does not go pending again.
        directed_rows.push_back(dir_row(CMD_SAMPLE, '0, '0, '1, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_WRITE, THRESH_ADDR, '1, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  THRESH_ADDR, '0, '0, 1, 32'd7, 1'b0));
        // Completions with an invalid id are dropped, then the real one.
        directed_rows.push_back(dir_row(CMD_WRITE, CLAIM_ADDR, 32'd0, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_WRITE, CLAIM_ADDR, 32'd64, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_WRITE, CLAIM_ADDR, 32'd63, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_UNUSED, '1, '1, '1, 1, 32'd0, 1'b0));
        // Two sources at equal priority: the lower id is claimed first.
        directed_rows.push_back(dir_row(CMD_WRITE, THRESH_ADDR, '0, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_WRITE, PRIO_BASE + 22'h4, 32'd5, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_WRITE, PRIO_BASE + 22'h8, 32'd5, '0, 0, '0, 1'b0));
        directed_rows.push_back(dir_row(CMD_READ,  CLAIM_ADDR, '0, '0, 1, 32'd1, 1'b1));

        // Synchronous reset, asserted once.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            drive_word(directed_rows[k]);

        // Random part. Most words are well formed (source sampling, claims, completions of
        // sources that are really in service, priority, enable and threshold updates) so
        // that sources cycle through pending, in service and back. The rest is noise:
        // random addresses, invalid ids and the undefined command. Fields a command does
        // not use still carry random values.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0) begin
                src_idle_on = ($urandom_range(0, 2) != 0);
                snk_idle_on = ($urandom_range(0, 2) != 0);
            end
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet_tail = 1'b1;

            w.typed = 0;
            w.want  = '0;
            w.cmd   = CMD_SAMPLE;
            w.addr  = ADDR_W'($urandom_range(0, 32'h3F_FFFF));
            w.data  = $urandom();
            w.lines = {$urandom(), $urandom()};
            sel     = $urandom_range(0, 99);

            if (sel < 24) begin
                w.cmd = CMD_SAMPLE;
                case ($urandom_range(0, 2))
                    0: w.lines = LINE_W'(1) << $urandom_range(0, LINE_W - 1);
                    1: w.lines = {$urandom(), $urandom()} & {$urandom(), $urandom()} &
                                 {$urandom(), $urandom()};
                    default: begin
                    end
                endcase
            end else if (sel < 40) begin
                w.cmd  = CMD_READ;
                w.addr = CLAIM_ADDR | ADDR_W'($urandom_range(0, 3));
            end else if (sel < 54) begin
                // Completion: usually an id that is really in service.
                w.cmd  = CMD_WRITE;
                w.addr = CLAIM_ADDR | ADDR_W'($urandom_range(0, 3));
                busy_ids.delete();
                for (int s = 1; s < NUM_SOURCES; s++)
                    if (shadow_insvc[s])
                        busy_ids.push_back(s);
                if (busy_ids.size() != 0 && $urandom_range(0, 4) != 0) begin
                    w.data = DATA_W'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       w.data = '0;
                        1:       w.data = DATA_W'(NUM_SOURCES + $urandom_range(0, 8));
                        default: w.data = $urandom();
                    endcase
                end
            end else if (sel < 64) begin
                src    = $urandom_range(0, NUM_SOURCES + 6);
                w.cmd  = CMD_WRITE;
                w.addr = PRIO_BASE + ADDR_W'(4 * src) + ADDR_W'($urandom_range(0, 3));
            end else if (sel < 71) begin
                wi     = $urandom_range(0, NWORDS);
                w.cmd  = CMD_WRITE;
                w.addr = ENAB_BASE + ADDR_W'(4 * wi) + ADDR_W'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0)
                    w.data = '1;
            end else if (sel < 76) begin
                // Keep the threshold low most of the time so that claims succeed.
                w.cmd     = CMD_WRITE;
                w.addr    = THRESH_ADDR | ADDR_W'($urandom_range(0, 3));
                w.data[2] = ($urandom_range(0, 3) == 0);
            end else if (sel < 86) begin
                w.cmd = CMD_READ;
                case ($urandom_range(0, 3))
                    0: w.addr = PRIO_BASE + ADDR_W'(4 * $urandom_range(0, NUM_SOURCES + 6));
                    1: w.addr = PEND_BASE + ADDR_W'(4 * $urandom_range(0, NWORDS));
                    2: w.addr = ENAB_BASE + ADDR_W'(4 * $urandom_range(0, NWORDS));
                    default: w.addr = THRESH_ADDR;
                endcase
                w.addr = w.addr | ADDR_W'($urandom_range(0, 3));
            end else if (sel < 95) begin
                // Anywhere in the address space, read or write.
                w.cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
            end else begin
                w.cmd = CMD_UNUSED;
            end
            drive_word(w);
        end
        req_ch.valid <= 1'b0;

        // Drain: wait for every owed response, then watch for stray ones.
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += awaited_results.size();

        $display("Covered %0d words: %0d samples, %0d reads, %0d writes, %0d undefined commands.",
                 sample_count + read_count + write_count + other_count,
                 sample_count, read_count, write_count, other_count);
        $display("Claims granted: %0d; responses with the interrupt raised: %0d; failures: %0d.",
                 grants, irq_seen, fail_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
